>>> rtl/chp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chp_pkg: coin hopper payout shared definitions
// Transaction payloads, configuration set, controller state and codes.
// ----------------------------------------------------------------------------
package chp_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_PICKUP_TIMEOUT = 3'd0;
    localparam logic [2:0] CFG_EXIT_TIMEOUT   = 3'd1;
    localparam logic [2:0] CFG_RESET_PAUSE    = 3'd2;
    localparam logic [2:0] CFG_RETRY_LIMIT    = 3'd3;
    localparam logic [2:0] CFG_CLOSE_SETTLE   = 3'd4;
    localparam logic [2:0] CFG_OPEN_SETTLE    = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Reset values of the configuration registers
    localparam logic [15:0] PICKUP_TIMEOUT_RST = 16'd5000;
    localparam logic [15:0] EXIT_TIMEOUT_RST   = 16'd1000;
    localparam logic [15:0] RESET_PAUSE_RST    = 16'd2000;
    localparam logic [1:0]  RETRY_LIMIT_RST    = 2'd3;
    localparam logic [7:0]  CLOSE_SETTLE_RST   = 8'd20;
    localparam logic [7:0]  OPEN_SETTLE_RST    = 8'd5;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_PICKUP = 2'd1,
        PH_PAUSE  = 2'd2,
        PH_EXIT   = 2'd3
    } phase_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] coin_count;
        logic       switch_open;
    } in_t;

    typedef struct packed {
        logic        motor_on;
        logic        busy_res;
        logic        finished;
        logic        failed;
        logic [7:0]  coins_paid;
        logic [7:0]  coins_left;
        logic [15:0] total_out;
        logic        error_latched;
        logic        switch_closed;
    } out_t;

    typedef struct packed {
        logic [15:0] pickup_timeout_ticks;
        logic [15:0] exit_timeout_ticks;
        logic [15:0] reset_pause_ticks;
        logic [1:0]  retry_limit;
        logic [7:0]  close_settle_ticks;
        logic [7:0]  open_settle_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  remaining;
        logic [7:0]  paid;
        logic [15:0] phase_timer;
        logic [1:0]  tries_left;
        logic        settled_closed;
        logic [7:0]  settle_timer;
        logic [15:0] coins_total;
        logic        error_mark;
        logic        motor;
    } state_t;

endpackage : chp_pkg
`default_nettype wire

>>> rtl/chp_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chp_step: one controller step
// Next state and result for one tick or start command.
// ----------------------------------------------------------------------------
module chp_step
    import chp_pkg::*;
(
    input  wire cfg_t   cfg,
    input  wire state_t cur,
    input  wire in_t    item,
    output state_t      nxt,
    output out_t        res
);

    state_t     s;
    logic       fin;
    logic       fail;
    logic       raw_closed;
    logic [7:0] delay;

    always_comb
    begin
        s          = cur;
        fin        = 1'b0;
        fail       = 1'b0;
        raw_closed = ~item.switch_open;
        delay      = 8'd0;

        if (item.mode) begin
            if (s.phase == PH_IDLE) begin
                s.paid      = 8'd0;
                s.remaining = item.coin_count;
                if (item.coin_count == 8'd0) begin
                    // empty payout ends at once
                    s.motor       = 1'b0;
                    s.phase_timer = 16'd0;
                    fin           = 1'b1;
                end else begin
                    s.tries_left  = cfg.retry_limit;
                    s.phase_timer = 16'd0;
                    s.motor       = 1'b1;
                    s.phase       = s.settled_closed ? PH_EXIT : PH_PICKUP;
                end
            end
        end else begin
            // switch settling, direction-dependent delay
            if (raw_closed == s.settled_closed) begin
                s.settle_timer = 8'd0;
            end else begin
                delay = s.settled_closed ? cfg.open_settle_ticks : cfg.close_settle_ticks;
                if (s.settle_timer >= delay) begin
                    s.settled_closed = raw_closed;
                    s.settle_timer   = 8'd0;
                end else begin
                    s.settle_timer = s.settle_timer + 8'd1;
                end
            end

            case (s.phase)
                PH_PICKUP:
                begin
                    if (s.settled_closed) begin
                        s.phase       = PH_EXIT;
                        s.phase_timer = 16'd0;
                    end else begin
                        if (s.phase_timer != 16'hFFFF)
                            s.phase_timer = s.phase_timer + 16'd1;
                        if (s.phase_timer >= cfg.pickup_timeout_ticks) begin
                            if (s.tries_left <= 2'd1) begin
                                s.tries_left = 2'd0;
                                fin          = 1'b1;
                                fail         = 1'b1;
                            end else begin
                                s.tries_left  = s.tries_left - 2'd1;
                                s.motor       = 1'b0;
                                s.phase       = PH_PAUSE;
                                s.phase_timer = 16'd0;
                            end
                        end
                    end
                end
                PH_PAUSE:
                begin
                    if (s.phase_timer != 16'hFFFF)
                        s.phase_timer = s.phase_timer + 16'd1;
                    if (s.phase_timer >= cfg.reset_pause_ticks) begin
                        s.phase       = PH_PICKUP;
                        s.phase_timer = 16'd0;
                        s.motor       = 1'b1;
                    end
                end
                PH_EXIT:
                begin
                    if (!s.settled_closed) begin
                        s.paid      = s.paid + 8'd1;
                        s.remaining = s.remaining - 8'd1;
                        if (s.remaining == 8'd0) begin
                            fin = 1'b1;
                        end else begin
                            s.tries_left  = cfg.retry_limit;
                            s.phase_timer = 16'd0;
                            s.motor       = 1'b1;
                            s.phase       = PH_PICKUP;
                        end
                    end else begin
                        if (s.phase_timer != 16'hFFFF)
                            s.phase_timer = s.phase_timer + 16'd1;
                        if (s.phase_timer >= cfg.exit_timeout_ticks) begin
                            fin  = 1'b1;
                            fail = 1'b1;
                        end
                    end
                end
                default:
                begin
                    s.phase = PH_IDLE;
                end
            endcase
        end

        // end of payout: stop motor, book coins, latch error on failure
        if (fin) begin
            s.motor       = 1'b0;
            s.phase       = PH_IDLE;
            s.phase_timer = 16'd0;
            s.coins_total = s.coins_total + {8'd0, s.paid};
            if (fail)
                s.error_mark = 1'b1;
        end

        nxt               = s;
        res.motor_on      = s.motor;
        res.busy_res      = (s.phase != PH_IDLE);
        res.finished      = fin;
        res.failed        = fail;
        res.coins_paid    = s.paid;
        res.coins_left    = s.remaining;
        res.total_out     = s.coins_total;
        res.error_latched = s.error_mark;
        res.switch_closed = s.settled_closed;
    end

endmodule : chp_step
`default_nettype wire

>>> rtl/coin_hopper_payout_controller_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// coin_hopper_payout_controller_top: coin hopper payout controller
// Tick-driven hopper motor control with switch settling, retries and totals.
// ----------------------------------------------------------------------------
// Each input transaction is either one time tick (mode 0, with the raw exit
// switch level) or a start-payout command (mode 1, with a coin count), and
// each produces exactly one result transaction. The controller state is
// updated in the cycle the input is accepted, and the result is loaded
// into the output register at the same edge. Throughput is one transaction
// per clock: the whole step is a single pass of counter and compare logic,
// and input is accepted whenever the output register is empty or is being
// drained in the same cycle. Configuration writes take effect at once and
// are meant to be done while no payout is running.
// ----------------------------------------------------------------------------
module coin_hopper_payout_controller_top
    import chp_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    // input transactions
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire in_t               in_data,
    // result transactions
    output logic                   out_valid,
    input  wire                    out_ready,
    output out_t                   out_data,
    // configuration writes
    input  wire                    cfg_we,
    input  wire [CFG_INDEX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0]   cfg_data
);

    cfg_t   cfg_reg;
    state_t state_reg;
    state_t state_next;
    out_t   res_next;
    out_t   out_reg;
    logic   out_valid_reg;
    logic   accept;

    // Room for a new transaction when the result slot is free or draining.
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.pickup_timeout_ticks <= PICKUP_TIMEOUT_RST;
            cfg_reg.exit_timeout_ticks   <= EXIT_TIMEOUT_RST;
            cfg_reg.reset_pause_ticks    <= RESET_PAUSE_RST;
            cfg_reg.retry_limit          <= RETRY_LIMIT_RST;
            cfg_reg.close_settle_ticks   <= CLOSE_SETTLE_RST;
            cfg_reg.open_settle_ticks    <= OPEN_SETTLE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PICKUP_TIMEOUT: cfg_reg.pickup_timeout_ticks <= cfg_data;
                CFG_EXIT_TIMEOUT:   cfg_reg.exit_timeout_ticks   <= cfg_data;
                CFG_RESET_PAUSE:    cfg_reg.reset_pause_ticks    <= cfg_data;
                CFG_RETRY_LIMIT:    cfg_reg.retry_limit          <= cfg_data[1:0];
                CFG_CLOSE_SETTLE:   cfg_reg.close_settle_ticks   <= cfg_data[7:0];
                CFG_OPEN_SETTLE:    cfg_reg.open_settle_ticks    <= cfg_data[7:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // Step logic: settle, phase machine, payout bookkeeping
    chp_step u_step (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (in_data),
        .nxt  (state_next),
        .res  (res_next)
    );

    // Controller state advances only on an accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '{
                phase:          PH_IDLE,
                remaining:      8'd0,
                paid:           8'd0,
                phase_timer:    16'd0,
                tries_left:     2'd0,
                settled_closed: 1'b0,
                settle_timer:   8'd0,
                coins_total:    16'd0,
                error_mark:     1'b0,
                motor:          1'b0
            };
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Result slot: valid flag under reset, payload loaded on accept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            out_reg <= res_next;
        end
    end

endmodule : coin_hopper_payout_controller_top
`default_nettype wire

>>> test/tb_coin_hopper_payout_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_coin_hopper_payout_controller_top: coin hopper payout controller bench
// Sends tick and start transactions with random idling on both channels,
// predicts every status transaction and checks each one field by field.
// ----------------------------------------------------------------------------

class hopper_checker;
    chp_pkg::cfg_t    cfg;
    chp_pkg::phase_t  phase;
    logic [7:0]       left;
    logic [7:0]       paid_cnt;
    logic [15:0]      ptimer;
    logic [1:0]       tries;
    logic             closed;
    logic [7:0]       stimer;
    logic [15:0]      total;
    logic             err;
    logic             motor;
    chp_pkg::out_t    status_q[$];
    int               errors;

    function new();
        errors                   = 0;
        cfg.pickup_timeout_ticks = chp_pkg::PICKUP_TIMEOUT_RST;
        cfg.exit_timeout_ticks   = chp_pkg::EXIT_TIMEOUT_RST;
        cfg.reset_pause_ticks    = chp_pkg::RESET_PAUSE_RST;
        cfg.retry_limit          = chp_pkg::RETRY_LIMIT_RST;
        cfg.close_settle_ticks   = chp_pkg::CLOSE_SETTLE_RST;
        cfg.open_settle_ticks    = chp_pkg::OPEN_SETTLE_RST;
        phase                    = chp_pkg::PH_IDLE;
        left                     = '0;
        paid_cnt                 = '0;
        ptimer                   = '0;
        tries                    = '0;
        closed                   = 1'b0;
        stimer                   = '0;
        total                    = '0;
        err                      = 1'b0;
        motor                    = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            chp_pkg::CFG_PICKUP_TIMEOUT: cfg.pickup_timeout_ticks = val;
            chp_pkg::CFG_EXIT_TIMEOUT:   cfg.exit_timeout_ticks   = val;
            chp_pkg::CFG_RESET_PAUSE:    cfg.reset_pause_ticks    = val;
            chp_pkg::CFG_RETRY_LIMIT:    cfg.retry_limit          = val[1:0];
            chp_pkg::CFG_CLOSE_SETTLE:   cfg.close_settle_ticks   = val[7:0];
            chp_pkg::CFG_OPEN_SETTLE:    cfg.open_settle_ticks    = val[7:0];
            default: ;
        endcase
    endfunction

    function bit busy();
        return phase != chp_pkg::PH_IDLE;
    endfunction

    function int pending();
        return status_q.size();
    endfunction

    function void start_coin();
        tries  = cfg.retry_limit;
        ptimer = '0;
        motor  = 1'b1;
        phase  = closed ? chp_pkg::PH_EXIT : chp_pkg::PH_PICKUP;
    endfunction

    function void close_payout(bit fail);
        motor  = 1'b0;
        phase  = chp_pkg::PH_IDLE;
        ptimer = '0;
        total  = total + 16'(paid_cnt);
        if (fail)
            err = 1'b1;
    endfunction

    function void bump_timer();
        if (ptimer != 16'hFFFF)
            ptimer = ptimer + 16'd1;
    endfunction

    // debounce: a change is taken on the tick after the delay ran out
    function void settle_switch(logic raw_closed);
        logic [7:0] delay;
        if (raw_closed == closed)
        begin
            stimer = '0;
        end
        else
        begin
            delay = closed ? cfg.open_settle_ticks : cfg.close_settle_ticks;
            if (stimer >= delay)
            begin
                closed = raw_closed;
                stimer = '0;
            end
            else if (stimer != 8'hFF)
            begin
                stimer = stimer + 8'd1;
            end
        end
    endfunction

    function chp_pkg::out_t next_status(chp_pkg::in_t d);
        chp_pkg::out_t s;
        bit            fin;
        bit            fail;
        fin  = 1'b0;
        fail = 1'b0;
        if (d.mode)
        begin
            // start while busy is dropped
            if (phase == chp_pkg::PH_IDLE)
            begin
                paid_cnt = '0;
                left     = d.coin_count;
                if (left == 8'd0)
                begin
                    close_payout(1'b0);
                    fin = 1'b1;
                end
                else
                begin
                    start_coin();
                end
            end
        end
        else
        begin
            settle_switch(!d.switch_open);
            case (phase)
                chp_pkg::PH_PICKUP:
                begin
                    if (closed)
                    begin
                        phase  = chp_pkg::PH_EXIT;
                        ptimer = '0;
                    end
                    else
                    begin
                        bump_timer();
                        if (ptimer >= cfg.pickup_timeout_ticks)
                        begin
                            // limit of zero behaves like one
                            if (tries <= 2'd1)
                            begin
                                tries = '0;
                                close_payout(1'b1);
                                fin  = 1'b1;
                                fail = 1'b1;
                            end
                            else
                            begin
                                tries  = tries - 2'd1;
                                motor  = 1'b0;
                                phase  = chp_pkg::PH_PAUSE;
                                ptimer = '0;
                            end
                        end
                    end
                end
                chp_pkg::PH_PAUSE:
                begin
                    bump_timer();
                    if (ptimer >= cfg.reset_pause_ticks)
                    begin
                        phase  = chp_pkg::PH_PICKUP;
                        ptimer = '0;
                        motor  = 1'b1;
                    end
                end
                chp_pkg::PH_EXIT:
                begin
                    if (!closed)
                    begin
                        paid_cnt = paid_cnt + 8'd1;
                        left     = left - 8'd1;
                        if (left == 8'd0)
                        begin
                            close_payout(1'b0);
                            fin = 1'b1;
                        end
                        else
                        begin
                            start_coin();
                        end
                    end
                    else
                    begin
                        bump_timer();
                        if (ptimer >= cfg.exit_timeout_ticks)
                        begin
                            close_payout(1'b1);
                            fin  = 1'b1;
                            fail = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        s.motor_on      = motor;
        s.busy_res      = (phase != chp_pkg::PH_IDLE);
        s.finished      = fin;
        s.failed        = fail;
        s.coins_paid    = paid_cnt;
        s.coins_left    = left;
        s.total_out     = total;
        s.error_latched = err;
        s.switch_closed = closed;
        return s;
    endfunction

    function void note_command(chp_pkg::in_t d);
        status_q.push_back(next_status(d));
    endfunction

    function void cmp(string field_name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field_name, want, got);
        end
    endfunction

    function void check_status(chp_pkg::out_t got);
        chp_pkg::out_t want;
        if (status_q.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected status, expected none, actual %h", $time, got);
            return;
        end
        want = status_q.pop_front();
        cmp("motor_on",      16'(want.motor_on),      16'(got.motor_on));
        cmp("busy_res",      16'(want.busy_res),      16'(got.busy_res));
        cmp("finished",      16'(want.finished),      16'(got.finished));
        cmp("failed",        16'(want.failed),        16'(got.failed));
        cmp("coins_paid",    16'(want.coins_paid),    16'(got.coins_paid));
        cmp("coins_left",    16'(want.coins_left),    16'(got.coins_left));
        cmp("total_out",     want.total_out,          got.total_out);
        cmp("error_latched", 16'(want.error_latched), 16'(got.error_latched));
        cmp("switch_closed", 16'(want.switch_closed), 16'(got.switch_closed));
    endfunction
endclass

module tb_coin_hopper_payout_controller_top;
    import chp_pkg::*;

    // No transaction on either channel for this many cycles means a hang.
    // Worst correct gap is a sender gap plus an output stall, or a short run
    // of config writes, so this is far beyond it.
    localparam int WATCHDOG_LIMIT = 500;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_t                    in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_t                   out_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    hopper_checker chk;
    bit            no_idle;        // both sides run back to back while set
    int            commands_sent;  // accepted commands that do something
    int            quiet_cycles;

    coin_hopper_payout_controller_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Wait drawn at random per transaction, none in burst stretches
    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    // Closed/open hold length: mostly long enough to settle, sometimes
    // a bounce that may or may not get through the debounce
    function automatic int hold_len(int settle);
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, settle + 3);
        return settle + 1 + $urandom_range(0, 3);
    endfunction

    // ------------------------------------------------------------------
    // Input side. Valid is raised at a falling edge and held with the
    // same payload until a rising edge sees ready. It is only lowered at
    // the next falling edge when a gap is drawn, so it never drops and
    // rises in the same step.
    // ------------------------------------------------------------------
    task automatic send_cmd(in_t d);
        int gap;
        gap = draw_wait();
        if (!(d.mode && chk.busy()))
            commands_sent++;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        do @(posedge clk); while (!in_ready);
        chk.note_command(d);
    endtask

    // coin_count rides along on ticks with random content; it is ignored
    task automatic send_tick(bit sw);
        in_t d;
        d.mode        = 1'b0;
        d.coin_count  = 8'($urandom_range(0, 255));
        d.switch_open = sw;
        send_cmd(d);
    endtask

    task automatic send_start(int n);
        in_t d;
        d.mode        = 1'b1;
        d.coin_count  = 8'(n);
        d.switch_open = 1'($urandom_range(0, 1));
        send_cmd(d);
    endtask

    task automatic send_noise(int max_coins);
        in_t d;
        d.mode        = ($urandom_range(0, 3) == 0);
        d.switch_open = 1'($urandom_range(0, 1));
        // keep payouts short unless the start is going to be dropped anyway
        if (d.mode && !chk.busy())
            d.coin_count = 8'($urandom_range(0, max_coins));
        else
            d.coin_count = 8'($urandom_range(0, 255));
        send_cmd(d);
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Hold off the sender until every predicted status has come back
    task automatic quiesce();
        release_input();
        while (chk.pending() != 0) @(posedge clk);
    endtask

    // Config writes happen only with nothing in flight and no payout running.
    // Every command gives exactly one status, so draining the queue is enough.
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        chk.set_reg(idx, val);
    endtask

    task automatic load_setting(int pickup, int exit_to, int pause, int retry,
                                int close_s, int open_s);
        quiesce();
        write_reg(CFG_PICKUP_TIMEOUT, 16'(pickup));
        write_reg(CFG_EXIT_TIMEOUT,   16'(exit_to));
        write_reg(CFG_RESET_PAUSE,    16'(pause));
        write_reg(CFG_RETRY_LIMIT,    16'(retry));
        write_reg(CFG_CLOSE_SETTLE,   16'(close_s));
        write_reg(CFG_OPEN_SETTLE,    16'(open_s));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // A well formed payout: start, then per coin an open gap, maybe a short
    // bounce, a closed hold for pickup and an open hold for exit.
    task automatic run_payout(int max_coins);
        int n;
        n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, max_coins);
        send_start(n);
        for (int k = 0; k < n && chk.busy(); k++)
        begin
            repeat ($urandom_range(0, 3)) send_tick(1'b1);
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 2)) send_tick(1'b0);
            repeat (hold_len(chk.cfg.close_settle_ticks)) send_tick(1'b0);
            repeat (hold_len(chk.cfg.open_settle_ticks)) send_tick(1'b1);
            // start in the middle of a payout must be dropped
            if (chk.busy() && $urandom_range(0, 9) == 0)
                send_start($urandom_range(0, 255));
        end
    endtask

    // Pay out clean coins until the running payout is over (or times out)
    task automatic finish_payout();
        while (chk.busy())
        begin
            repeat (chk.cfg.close_settle_ticks + 2) send_tick(1'b0);
            repeat (chk.cfg.open_settle_ticks + 2) send_tick(1'b1);
        end
    endtask

    task automatic run_phase(int budget, int max_coins, bit burst);
        int first;
        first   = commands_sent;
        no_idle = burst;
        while (commands_sent - first < budget)
        begin
            if ($urandom_range(0, 39) == 0)
                quiesce();
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 8)) send_noise(max_coins);
            else
                run_payout(max_coins);
        end
        finish_payout();
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: a stall drawn per status transaction, then ready held
    // until a rising edge takes one.
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait();
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            chk.check_status(out_data);
        end
    end

    // Watchdog on transaction progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        chk           = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        no_idle       = 1'b0;
        commands_sent = 0;
        quiet_cycles  = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset config: debounce counts up but a closed level does not
        // settle yet; empty payout ends at once with success.
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_start(0);

        // Shortest timeouts, no settle delay, no pause, retry limit zero
        load_setting(1, 1, 0, 0, 0, 0);
        send_tick(1'b0);          // settles closed on the spot
        send_tick(1'b1);          // and open again
        send_start(0);
        send_start(255);          // largest count
        send_start(3);            // dropped, payout already running
        send_tick(1'b1);          // first pickup timeout fails the payout
        send_tick(1'b0);
        send_start(1);            // switch already closed: straight to exit
        send_tick(1'b1);          // coin leaves, payout done

        // Pickup timeout with a retry, pause, coin paid, then exit timeout
        load_setting(3, 2, 1, 2, 1, 1);
        send_start(2);
        repeat (3) send_tick(1'b1);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        repeat (2) send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        repeat (2) send_tick(1'b0);

        // Random phases over a spread of settings; the slow-settle phase
        // runs several hundred ticks per coin, so its budget is small
        load_setting(20, 15, 3, 3, 2, 1);
        run_phase(120, 6, 1'b0);
        load_setting(4, 3, 0, 1, 0, 0);
        run_phase(80, 4, 1'b1);
        load_setting(65535, 65535, 65535, 2, 3, 2);
        run_phase(100, 8, 1'b0);
        load_setting(1500, 1500, 40, 3, 255, 255);
        run_phase(50, 1, 1'b0);
        load_setting(8, 6, 2, 2, 1, 3);
        run_phase(120, 10, 1'b0);

        quiesce();
        repeat (10) @(posedge clk);
        if (chk.errors == 0 && chk.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
